### rtl/axis_min_max_argmax_reducer_assert.svh
// assertion macros shared by the checker
`ifndef AXIS_MIN_MAX_ARGMAX_REDUCER_ASSERT_SVH
`define AXIS_MIN_MAX_ARGMAX_REDUCER_ASSERT_SVH

`define AMR_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define AMR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

### rtl/amr_pkg.sv
package amr_pkg;
    localparam int MaxColumns = 1024;
    localparam int MaxRows    = 65536;
    localparam int ColBits    = 10;
    localparam int RowBits    = 16;
    localparam int EntryBits  = 80;

    localparam logic [63:0] SentinelPos = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SentinelNeg = 64'hFFEF_FFFF_FFFF_FFFF;

    localparam logic [1:0] RegMode   = 2'd0;
    localparam logic [1:0] RegAxis   = 2'd1;
    localparam logic [1:0] RegRows   = 2'd2;
    localparam logic [1:0] RegCols   = 2'd3;

    // a < b on raw double bits; any nan gives false, -0 equals +0
    function automatic logic f_less(input logic [63:0] a, input logic [63:0] b);
        logic a_nan, b_nan, both_zero;
        a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        if (a_nan || b_nan || both_zero) return 1'b0;
        if (a[63] != b[63]) return a[63];
        if (a[63]) return a[62:0] > b[62:0];
        return a[62:0] < b[62:0];
    endfunction
endpackage

### rtl/amr_ram.sv
module amr_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### rtl/axis_min_max_argmax_reducer.sv
// min / max / argmin / argmax reducer over a row-major array of doubles.
// s_axis: one double per transaction in s_axis_tdata, row after row.
// m_axis: one result transaction when the last element of a reduced line
//   arrives: tdata holds result_slot, best_value, best_position; tlast marks
//   the final result of the whole array.
// apb: mode @0, axis @4, row_count @8, column_count @12; any write restarts
//   the array at position zero.
// throughput: one sample per cycle while s_axis_tready is high. each sample
//   reads its running entry from the column memory in stage 1 and writes it
//   back at the end of stage 1; a hit on the entry just being written is forwarded.
// output: a line's result goes from stage 1 into the result buffer, then to m_axis.
// reset: mode argmax, axis 0, one by one array, pipeline empty. the memory
//   needs no clearing since a line's first sample always writes its entry.
// stall: when m_axis is held, a three-entry result buffer absorbs the
//   in-flight results and s_axis_tready falls once it cannot take another.
module axis_min_max_argmax_reducer
    import amr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // sample
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // result_slot, best_value, best_position
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [1:0]  r_mode;
    logic        r_axis;
    logic [16:0] r_rows;
    logic [10:0] r_cols;
    logic [16:0] eff_rows;
    logic [10:0] eff_cols;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'd3;
            r_axis <= 1'b0;
            r_rows <= 17'd1;
            r_cols <= 11'd1;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                RegMode: r_mode <= pwdata[1:0];
                RegAxis: r_axis <= pwdata[0];
                RegRows: r_rows <= pwdata[16:0];
                RegCols: r_cols <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegMode: prdata = {30'd0, r_mode};
            RegAxis: prdata = {31'd0, r_axis};
            RegRows: prdata = {15'd0, r_rows};
            RegCols: prdata = {21'd0, r_cols};
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        eff_rows = (r_rows == 17'd0) ? 17'd1 :
                   ((r_rows > 17'(MaxRows)) ? 17'(MaxRows) : r_rows);
        eff_cols = (r_cols == 11'd0) ? 11'd1 :
                   ((r_cols > 11'(MaxColumns)) ? 11'(MaxColumns) : r_cols);
    end

    // position counters
    logic [RowBits-1:0] r_row_pos;
    logic [ColBits-1:0] r_col_pos;
    logic               in_fire;
    logic               col_end, row_end;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign col_end = ({1'b0, r_col_pos} == eff_cols - 11'd1);
    assign row_end = ({1'b0, r_row_pos} == eff_rows - 17'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_we) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (in_fire) begin
            if (col_end) begin
                r_col_pos <= '0;
                r_row_pos <= row_end ? '0 : r_row_pos + RowBits'(1);
            end else begin
                r_col_pos <= r_col_pos + ColBits'(1);
            end
        end
    end

    // stage 1: read issued
    logic               r_s1_valid;
    logic [63:0]        r_s1_sample;
    logic [ColBits-1:0] r_s1_entry;
    logic [RowBits-1:0] r_s1_slot;
    logic [RowBits-1:0] r_s1_rpos;
    logic               r_s1_first, r_s1_emit, r_s1_last;
    logic [ColBits-1:0] rd_entry;
    logic               line_end;

    assign rd_entry = r_axis ? '0 : r_col_pos;
    assign line_end = r_axis ? col_end : row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else          r_s1_valid <= in_fire;
        if (in_fire) begin
            r_s1_sample <= s_axis_tdata;
            r_s1_entry  <= rd_entry;
            r_s1_slot   <= r_axis ? r_row_pos : {6'd0, r_col_pos};
            r_s1_rpos   <= r_axis ? {6'd0, r_col_pos} : r_row_pos;
            r_s1_first  <= r_axis ? (r_col_pos == '0) : (r_row_pos == '0);
            r_s1_emit   <= line_end;
            r_s1_last   <= r_axis ? row_end : col_end;
        end
    end

    logic [EntryBits-1:0] rd_data;
    logic                 wr_en;
    logic [ColBits-1:0]   r_wr_entry;
    logic [EntryBits-1:0] r_wr_data;
    logic                 r_wr_valid;

    // forward the entry being written when stage 1 reads it
    logic [63:0]        cur_val;
    logic [RowBits-1:0] cur_pos;
    logic [63:0]        new_val;
    logic [RowBits-1:0] new_pos;
    logic               max_mode, better;

    assign max_mode = r_mode[0];

    always_comb begin
        if (r_s1_first) begin
            cur_val = max_mode ? SentinelNeg : SentinelPos;
            cur_pos = '0;
        end else if (r_wr_valid && r_wr_entry == r_s1_entry) begin
            cur_val = r_wr_data[79:16];
            cur_pos = r_wr_data[15:0];
        end else begin
            cur_val = rd_data[79:16];
            cur_pos = rd_data[15:0];
        end
        better  = max_mode ? f_less(cur_val, r_s1_sample) : f_less(r_s1_sample, cur_val);
        new_val = better ? r_s1_sample : cur_val;
        new_pos = better ? r_s1_rpos : cur_pos;
    end

    assign wr_en = r_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wr_valid <= 1'b0;
        else          r_wr_valid <= wr_en;
        if (wr_en) begin
            r_wr_entry <= r_s1_entry;
            r_wr_data  <= {new_val, new_pos};
        end
    end

    amr_ram #(.Width(EntryBits), .Depth(MaxColumns)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_entry),
        .i_wdata ({new_val, new_pos}),
        .i_raddr (rd_entry),
        .o_rdata (rd_data)
    );

    // stage 2: result buffer (three entries, head in r_q[0])
    logic        emit;
    logic [96:0] emit_data;
    logic [96:0] r_q [3];
    logic [96:0] n_q [3];
    logic [1:0]  r_cnt;
    logic [1:0]  wr_idx;
    logic        out_fire;

    assign emit      = r_s1_valid && r_s1_emit;
    assign emit_data = {r_s1_last, new_pos, new_val, r_s1_slot};
    assign out_fire  = m_axis_tvalid && m_axis_tready;
    assign wr_idx    = r_cnt - {1'b0, out_fire};

    always_comb begin
        n_q = r_q;
        if (out_fire) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        if (emit) n_q[wr_idx] = emit_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + {1'b0, emit} - {1'b0, out_fire};
        end
        r_q <= n_q;
    end

    // a result can still be in stage 1, keep room for it and the next sample
    assign s_axis_tready = (({1'b0, r_cnt} + {2'b0, emit}) < 3'd3);
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q[0][95:0];
    assign m_axis_tlast  = r_q[0][96];
endmodule

### rtl/amr_checker.sv
`include "axis_min_max_argmax_reducer_assert.svh"
module amr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        pready
);
    `AMR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `AMR_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `AMR_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
endmodule

bind axis_min_max_argmax_reducer amr_checker u_amr_checker (.*);
